// ===== rtl/ssc_pkg.sv =====
// Package for the segment/segment closest-point unit.
// Widths, pipeline latencies, register codes and the queue entry type.
// No dependencies.
package ssc_pkg;

  localparam int CW        = 32;             // coordinate width
  localparam int FRAC_BITS = 16;
  localparam int T_FRAC    = 30;             // fraction bits of s and t
  localparam int QW        = T_FRAC + 1;     // s, t in [0, 2^T_FRAC]
  localparam int DW        = CW + 1;         // difference vector component
  localparam int PRW       = 2 * DW;         // component product
  localparam int DOTW      = PRW + 1;        // dot product of three components
  localparam int MW        = DOTW + 1;       // wide multiplier operand
  localparam int MH        = MW / 2;
  localparam int PW2       = 2 * MW;         // wide multiplier product
  localparam int DVW       = PW2;            // divider operand width
  localparam int PAW       = 4;
  localparam int MUL_LAT   = 3;
  localparam int DIV_LAT   = T_FRAC + 1;
  localparam int FQ_D      = 4;
  localparam int FQ_AW     = $clog2(FQ_D);

  localparam logic [63:0] THR_RST = 64'((65'd1 << (2 * FRAC_BITS)) / 65'd3);
  localparam logic        REG_THR = 1'b0;

  typedef logic [2:0][CW-1:0] vec_t;
  typedef logic [2:0][DW-1:0] dvec_t;

  typedef struct packed {
    vec_t            p1;
    dvec_t           d1;
    vec_t            p2;
    dvec_t           d2;
    logic [DOTW-1:0] a;
    logic [DOTW-1:0] e;
    logic [DOTW-1:0] f;
    logic [DOTW-1:0] c;
    logic [DOTW-1:0] b;
    logic            deg1;
    logic            deg2;
  } fe_t;

endpackage

// ===== rtl/segment_segment_closest_points_unit.sv =====
// Closest points between two 3D segments, Q16.16 coordinates, Q32.32 squared distance.
// The time from input transfer to result grows only while the output is held.
// Throughput: one transfer per cycle unless stalled; the four 31-stage dividers and wide multipliers are pipelined.
// Reset (synchronous, rst_n low): pipeline and queue emptied, threshold set to 1/3.
// Depends on ssc_pkg, ssc_front, ssc_fifo, ssc_back.
module segment_segment_closest_points_unit import ssc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PAW-1:0]       paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] in_p1_x,
  input  logic signed [CW-1:0] in_p1_y,
  input  logic signed [CW-1:0] in_p1_z,
  input  logic signed [CW-1:0] in_q1_x,
  input  logic signed [CW-1:0] in_q1_y,
  input  logic signed [CW-1:0] in_q1_z,
  input  logic signed [CW-1:0] in_p2_x,
  input  logic signed [CW-1:0] in_p2_y,
  input  logic signed [CW-1:0] in_p2_z,
  input  logic signed [CW-1:0] in_q2_x,
  input  logic signed [CW-1:0] in_q2_y,
  input  logic signed [CW-1:0] in_q2_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [CW-1:0] out_near1_x,
  output logic signed [CW-1:0] out_near1_y,
  output logic signed [CW-1:0] out_near1_z,
  output logic signed [CW-1:0] out_near2_x,
  output logic signed [CW-1:0] out_near2_y,
  output logic signed [CW-1:0] out_near2_z,
  output logic [63:0]          out_dist_squared
);

  logic [63:0] thr_r;
  vec_t        p1, q1, p2, q2, near1, near2;
  fe_t         ent, head;
  logic        push, pop, full, empty;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_THR) ? thr_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RST;
    end else if (psel && penable && pwrite && paddr[3] == REG_THR) begin
      thr_r <= pwdata;
    end
  end

  assign p1 = {in_p1_z, in_p1_y, in_p1_x};
  assign q1 = {in_q1_z, in_q1_y, in_q1_x};
  assign p2 = {in_p2_z, in_p2_y, in_p2_x};
  assign q2 = {in_q2_z, in_q2_y, in_q2_x};

  ssc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .p1, .q1, .p2, .q2, .thr(thr_r), .full, .push, .ent
  );

  ssc_fifo u_fifo (
    .clk, .rst_n, .push, .wdata(ent), .pop, .rdata(head), .full, .empty
  );

  ssc_back u_back (
    .clk, .rst_n, .empty, .head, .pop, .out_valid, .out_stall,
    .near1, .near2, .dist_sq(out_dist_squared)
  );

  assign out_near1_x = near1[0];
  assign out_near1_y = near1[1];
  assign out_near1_z = near1[2];
  assign out_near2_x = near2[0];
  assign out_near2_y = near2[1];
  assign out_near2_z = near2[2];

endmodule

// ===== rtl/ssc_mul.sv =====
// Pipelined signed multiplier, MW x MW -> PW2, built from four half-width products.
// Three register stages with a common enable. Depends on ssc_pkg.
module ssc_mul import ssc_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [MW-1:0]  a,
  input  logic signed [MW-1:0]  b,
  output logic signed [PW2-1:0] p
);

  logic [MW-1:0]   ma_r, mb_r;
  logic            neg1_r, neg2_r;
  logic [2*MH-1:0] pll_r, plh_r, phl_r, phh_r;
  logic [PW2-1:0]  sum;

  always_comb begin
    sum = PW2'(pll_r) + (PW2'(plh_r) << MH) + (PW2'(phl_r) << MH) + (PW2'(phh_r) << (2 * MH));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= a[MW-1] ? -a : a;
      mb_r   <= b[MW-1] ? -b : b;
      neg1_r <= a[MW-1] ^ b[MW-1];
      pll_r  <= ma_r[MH-1:0] * mb_r[MH-1:0];
      plh_r  <= ma_r[MH-1:0] * mb_r[MW-1:MH];
      phl_r  <= ma_r[MW-1:MH] * mb_r[MH-1:0];
      phh_r  <= ma_r[MW-1:MH] * mb_r[MW-1:MH];
      neg2_r <= neg1_r;
      p      <= neg2_r ? -sum : sum;
    end
  end

endmodule

// ===== rtl/ssc_div.sv =====
// Pipelined restoring divider: q = floor(num * 2^T_FRAC / den), clamped to [0, 2^T_FRAC].
// One quotient bit per stage after an input stage, DIV_LAT stages with a common enable. Depends on ssc_pkg.
module ssc_div import ssc_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [DVW-1:0] num,
  input  logic signed [DVW-1:0] den,
  output logic [QW-1:0]         q
);

  logic [DVW-1:0]    rem_r [0:T_FRAC];
  logic [DVW-1:0]    den_r [0:T_FRAC];
  logic [T_FRAC-1:0] q_r   [0:T_FRAC];
  logic [T_FRAC:0]   zero_r;
  logic [T_FRAC:0]   one_r;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (den <= 0) || (num <= 0);
      one_r[0]  <= num >= den;
      rem_r[0]  <= num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= T_FRAC; k++) begin : g_st
    logic [DVW-1:0] r2;
    logic           ge;

    always_comb begin
      r2 = {rem_r[k-1][DVW-2:0], 1'b0};
      ge = r2 >= den_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? r2 - den_r[k-1] : r2;
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= {q_r[k-1][T_FRAC-2:0], ge};
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
      end
    end
  end

  always_comb begin
    if (zero_r[T_FRAC]) begin
      q = '0;
    end else if (one_r[T_FRAC]) begin
      q = QW'(1) << T_FRAC;
    end else begin
      q = {1'b0, q_r[T_FRAC]};
    end
  end

endmodule

// ===== rtl/ssc_front.sv =====
// Front end: takes a segment pair, forms direction vectors and the five dot products,
// and classifies each segment as point or segment against the threshold. Depends on ssc_pkg.
module ssc_front import ssc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  vec_t        p1,
  input  vec_t        q1,
  input  vec_t        p2,
  input  vec_t        q2,
  input  logic [63:0] thr,
  input  logic        full,
  output logic        push,
  output fe_t         ent
);

  logic                  adv;
  logic [3:0]            v_r;
  vec_t                  p1_0_r, q1_0_r, p2_0_r, q2_0_r;
  vec_t                  p1_1_r, p2_1_r, p1_2_r, p2_2_r, p1_3_r, p2_3_r;
  dvec_t                 d1_1_r, d2_1_r, r_1_r, d1_2_r, d2_2_r, d1_3_r, d2_3_r;
  logic [2:0][PRW-1:0]   aa_r, ee_r, ff_r, cc_r, bb_r;
  logic [DOTW-1:0]       a_r, e_r, f_r, c_r, b_r;

  assign adv      = !full;
  assign in_stall = full;
  assign push     = v_r[3] && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_0_r <= p1;
      q1_0_r <= q1;
      p2_0_r <= p2;
      q2_0_r <= q2;
      p1_1_r <= p1_0_r;
      p2_1_r <= p2_0_r;
      p1_2_r <= p1_1_r;
      p2_2_r <= p2_1_r;
      d1_2_r <= d1_1_r;
      d2_2_r <= d2_1_r;
      p1_3_r <= p1_2_r;
      p2_3_r <= p2_2_r;
      d1_3_r <= d1_2_r;
      d2_3_r <= d2_2_r;
      for (int i = 0; i < 3; i++) begin
        d1_1_r[i] <= $signed({q1_0_r[i][CW-1], q1_0_r[i]}) - $signed({p1_0_r[i][CW-1], p1_0_r[i]});
        d2_1_r[i] <= $signed({q2_0_r[i][CW-1], q2_0_r[i]}) - $signed({p2_0_r[i][CW-1], p2_0_r[i]});
        r_1_r[i]  <= $signed({p1_0_r[i][CW-1], p1_0_r[i]}) - $signed({p2_0_r[i][CW-1], p2_0_r[i]});
        aa_r[i]   <= $signed(d1_1_r[i]) * $signed(d1_1_r[i]);
        ee_r[i]   <= $signed(d2_1_r[i]) * $signed(d2_1_r[i]);
        ff_r[i]   <= $signed(d2_1_r[i]) * $signed(r_1_r[i]);
        cc_r[i]   <= $signed(d1_1_r[i]) * $signed(r_1_r[i]);
        bb_r[i]   <= $signed(d1_1_r[i]) * $signed(d2_1_r[i]);
      end
      a_r <= DOTW'($signed(aa_r[0])) + DOTW'($signed(aa_r[1])) + DOTW'($signed(aa_r[2]));
      e_r <= DOTW'($signed(ee_r[0])) + DOTW'($signed(ee_r[1])) + DOTW'($signed(ee_r[2]));
      f_r <= DOTW'($signed(ff_r[0])) + DOTW'($signed(ff_r[1])) + DOTW'($signed(ff_r[2]));
      c_r <= DOTW'($signed(cc_r[0])) + DOTW'($signed(cc_r[1])) + DOTW'($signed(cc_r[2]));
      b_r <= DOTW'($signed(bb_r[0])) + DOTW'($signed(bb_r[1])) + DOTW'($signed(bb_r[2]));
    end
  end

  // squared lengths are never negative, so an unsigned compare is exact
  always_comb begin
    ent.p1   = p1_3_r;
    ent.d1   = d1_3_r;
    ent.p2   = p2_3_r;
    ent.d2   = d2_3_r;
    ent.a    = a_r;
    ent.e    = e_r;
    ent.f    = f_r;
    ent.c    = c_r;
    ent.b    = b_r;
    ent.deg1 = a_r <= DOTW'(thr);
    ent.deg2 = e_r <= DOTW'(thr);
  end

endmodule

// ===== rtl/ssc_fifo.sv =====
// Short queue between the front end and the solver back end.
// Depends on ssc_pkg (entry type and depth).
module ssc_fifo import ssc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  fe_t  wdata,
  input  logic pop,
  output fe_t  rdata,
  output logic full,
  output logic empty
);

  fe_t              mem [FQ_D];
  logic [FQ_AW-1:0] wp_r, rp_r;
  logic [FQ_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FQ_AW+1)'(push) - (FQ_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

  assign rdata = mem[rp_r];
  assign full  = cnt_r == (FQ_AW+1)'(FQ_D);
  assign empty = cnt_r == '0;

endmodule

// ===== rtl/ssc_back.sv =====
// Back end: solves for s and t, clamps, forms both closest points and the squared distance.
// Fixed-latency pipeline that freezes as a whole while the output register is held.
// Depends on ssc_pkg, ssc_mul, ssc_div.
module ssc_back import ssc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        empty,
  input  fe_t         head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output vec_t        near1,
  output vec_t        near2,
  output logic [63:0] dist_sq
);

  localparam int B_DEN = MUL_LAT;
  localparam int B_S0  = B_DEN + 1 + DIV_LAT;
  localparam int B_TN  = B_S0 + MUL_LAT;
  localparam int B_D4  = B_TN + 1;
  localparam int B_SEL = B_D4 + DIV_LAT;
  localparam int B_ST  = B_SEL + 1;
  localparam int B_PR  = B_ST + 1;
  localparam int B_OUT = B_PR + 4;
  localparam int ALW   = DW + QW + 1;
  localparam int CXW   = CW + 2;
  localparam int SUMW  = 2 * CXW + 2;
  localparam logic [QW-1:0]         ONE = QW'(1) << T_FRAC;
  localparam logic signed [ALW-1:0] RND = ALW'(1) << (T_FRAC - 1);

  typedef struct packed {
    fe_t           e;
    logic [QW-1:0] s0;
    logic          tneg;
    logic          tbig;
  } ctx_t;

  logic                  adv;
  logic [B_OUT:0]        vld_r;
  ctx_t                  ctx_r   [0:B_PR];
  ctx_t                  ctx_nxt [0:B_PR];
  ctx_t                  cs;
  logic signed [PW2-1:0] p_ae, p_bb, p_bf, p_ce, p_bs;
  logic signed [DVW-1:0] dn_r, sn_r, tn, td, tn_r, td_r;
  logic signed [DVW-1:0] n4, d4, n2, d2, n3;
  logic [QW-1:0]         q_s0, q_t, q_sa, q_sb, s_sel, t_sel, s_r, t_r;
  logic [2:0][ALW-1:0]   pr1_r, pr2_r;
  logic [2:0][CXW-1:0]   c1_n, c2_n, c1_c_r, c2_c_r, c1_x_r, c2_x_r, c1_q_r, c2_q_r, x_r;
  logic [2:0][2*CXW-1:0] sq_r;
  logic [SUMW-1:0]       sum;
  logic signed [ALW-1:0] sh1, sh2;

  assign adv       = !(vld_r[B_OUT] && out_stall);
  assign pop       = adv && !empty;
  assign out_valid = vld_r[B_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[B_OUT-1:0], !empty};
    end
  end

  // context shift line, with results merged in where they become known
  always_comb begin
    ctx_nxt[0].e    = head;
    ctx_nxt[0].s0   = '0;
    ctx_nxt[0].tneg = 1'b0;
    ctx_nxt[0].tbig = 1'b0;
    for (int k = 1; k <= B_PR; k++) begin
      ctx_nxt[k] = ctx_r[k-1];
    end
    ctx_nxt[B_S0+1].s0   = q_s0;
    ctx_nxt[B_TN+1].tneg = tn[DVW-1];
    ctx_nxt[B_TN+1].tbig = tn > td;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= B_PR; k++) begin
        ctx_r[k] <= ctx_nxt[k];
      end
    end
  end

  ssc_mul u_mul_ae (.clk, .en(adv), .a(MW'($signed(ctx_r[0].e.a))),
                    .b(MW'($signed(ctx_r[0].e.e))), .p(p_ae));
  ssc_mul u_mul_bb (.clk, .en(adv), .a(MW'($signed(ctx_r[0].e.b))),
                    .b(MW'($signed(ctx_r[0].e.b))), .p(p_bb));
  ssc_mul u_mul_bf (.clk, .en(adv), .a(MW'($signed(ctx_r[0].e.b))),
                    .b(MW'($signed(ctx_r[0].e.f))), .p(p_bf));
  ssc_mul u_mul_ce (.clk, .en(adv), .a(MW'($signed(ctx_r[0].e.c))),
                    .b(MW'($signed(ctx_r[0].e.e))), .p(p_ce));

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_r <= p_ae - p_bb;
      sn_r <= p_bf - p_ce;
    end
  end

  // s on the infinite lines, clamped to [0, 1]; zero when the lines are parallel
  ssc_div u_div_s0 (.clk, .en(adv), .num(sn_r), .den(dn_r), .q(q_s0));

  ssc_mul u_mul_bs (.clk, .en(adv), .a(MW'($signed(ctx_r[B_S0].e.b))),
                    .b($signed(MW'(q_s0))), .p(p_bs));

  always_comb begin
    tn = p_bs + (DVW'($signed(ctx_r[B_TN].e.f)) <<< T_FRAC);
    td = DVW'($signed(ctx_r[B_TN].e.e)) <<< T_FRAC;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tn_r <= tn;
      td_r <= td;
    end
  end

  always_comb begin
    n4 = ctx_r[B_D4].e.deg1 ? DVW'($signed(ctx_r[B_D4].e.f)) : tn_r;
    d4 = ctx_r[B_D4].e.deg1 ? DVW'($signed(ctx_r[B_D4].e.e)) : td_r;
    n2 = -DVW'($signed(ctx_r[B_D4].e.c));
    d2 = DVW'($signed(ctx_r[B_D4].e.a));
    n3 = DVW'($signed(ctx_r[B_D4].e.b)) - DVW'($signed(ctx_r[B_D4].e.c));
  end

  ssc_div u_div_t  (.clk, .en(adv), .num(n4), .den(d4), .q(q_t));
  ssc_div u_div_sa (.clk, .en(adv), .num(n2), .den(d2), .q(q_sa));
  ssc_div u_div_sb (.clk, .en(adv), .num(n3), .den(d2), .q(q_sb));

  always_comb begin
    cs    = ctx_r[B_SEL];
    s_sel = '0;
    t_sel = '0;
    if (cs.e.deg1) begin
      if (!cs.e.deg2) t_sel = q_t;
    end else if (cs.e.deg2 || cs.tneg) begin
      s_sel = q_sa;
    end else if (cs.tbig) begin
      t_sel = ONE;
      s_sel = q_sb;
    end else begin
      t_sel = q_t;
      s_sel = cs.s0;
    end
  end

  // point = p + round(d * s), ties toward +inf, which is a floor after adding half
  always_comb begin
    sh1 = '0;
    sh2 = '0;
    for (int i = 0; i < 3; i++) begin
      sh1     = ($signed(pr1_r[i]) + RND) >>> T_FRAC;
      sh2     = ($signed(pr2_r[i]) + RND) >>> T_FRAC;
      c1_n[i] = CXW'($signed(ctx_r[B_PR].e.p1[i])) + CXW'(sh1);
      c2_n[i] = CXW'($signed(ctx_r[B_PR].e.p2[i])) + CXW'(sh2);
    end
    sum = SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r <= s_sel;
      t_r <= t_sel;
      for (int i = 0; i < 3; i++) begin
        pr1_r[i]  <= $signed(ctx_r[B_ST].e.d1[i]) * $signed({1'b0, s_r});
        pr2_r[i]  <= $signed(ctx_r[B_ST].e.d2[i]) * $signed({1'b0, t_r});
        x_r[i]    <= c1_c_r[i] - c2_c_r[i];
        sq_r[i]   <= $signed(x_r[i]) * $signed(x_r[i]);
        near1[i]  <= c1_q_r[i][CW-1:0];
        near2[i]  <= c2_q_r[i][CW-1:0];
      end
      c1_c_r  <= c1_n;
      c2_c_r  <= c2_n;
      c1_x_r  <= c1_c_r;
      c2_x_r  <= c2_c_r;
      c1_q_r  <= c1_x_r;
      c2_q_r  <= c2_x_r;
      dist_sq <= (|sum[SUMW-1:64]) ? '1 : sum[63:0];
    end
  end

  a_frozen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valids moved while output was held");

  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[B_ST] |-> (s_r <= ONE) && (t_r <= ONE))
    else $error("segment parameter outside [0,1]");

  a_both_points: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[B_SEL] && ctx_r[B_SEL].e.deg1 && ctx_r[B_SEL].e.deg2
    |=> (s_r == '0) && (t_r == '0))
    else $error("two point segments must give s = t = 0");

endmodule

// ===== bench/tb_segment_segment_closest_points_unit.sv =====
// Testbench for segment_segment_closest_points_unit: directed and random segment pairs,
// threshold register sweeps, random idling and backpressure, results checked in order.
// Depends on ssc_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_segment_segment_closest_points_unit import ssc_pkg::*; ();

  typedef logic signed [199:0] w_t;
  typedef logic [0:11][31:0] seg_pair_t;   // p1 xyz, q1 xyz, p2 xyz, q2 xyz
  typedef struct {
    logic [31:0] n1[3];
    logic [31:0] n2[3];
    logic [63:0] dsq;
  } near_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  seg_pair_t in_pt = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] out_n1_x, out_n1_y, out_n1_z, out_n2_x, out_n2_y, out_n2_z;
  logic [63:0] out_dsq;

  near_t exp_near_q[$];
  logic [63:0] thr_model;
  int mismatches = 0;
  bit idle_on = 1'b1;
  int hold_req = 0;
  int stall_burst = 0;

  segment_segment_closest_points_unit dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_p1_x(in_pt[0]), .in_p1_y(in_pt[1]), .in_p1_z(in_pt[2]),
    .in_q1_x(in_pt[3]), .in_q1_y(in_pt[4]), .in_q1_z(in_pt[5]),
    .in_p2_x(in_pt[6]), .in_p2_y(in_pt[7]), .in_p2_z(in_pt[8]),
    .in_q2_x(in_pt[9]), .in_q2_y(in_pt[10]), .in_q2_z(in_pt[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_near1_x(out_n1_x), .out_near1_y(out_n1_y), .out_near1_z(out_n1_z),
    .out_near2_x(out_n2_x), .out_near2_y(out_n2_y), .out_near2_z(out_n2_z),
    .out_dist_squared(out_dsq)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("segment_segment_closest_points_unit verification failed");
    $finish;
  end

  // floor(num * 2^30 / den), clamped to [0, 2^30]
  function automatic logic [30:0] frac_of(w_t num, w_t den);
    w_t q;
    if (den <= 0 || num <= 0) return '0;
    if (num >= den) return 31'(1) << T_FRAC;
    q = (num <<< T_FRAC) / den;
    return q[30:0];
  endfunction

  function automatic w_t dot3(w_t x[3], w_t y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  function automatic w_t along(w_t p, w_t d, logic [30:0] s);
    w_t sw, half;
    sw = w_t'(s);
    half = w_t'(1) <<< (T_FRAC - 1);
    return p + ((d * sw + half) >>> T_FRAC);
  endfunction

  function automatic near_t closest_points(seg_pair_t pt, logic [63:0] thr);
    w_t p1[3], q1[3], p2[3], q2[3], d1[3], d2[3], r[3], x[3], c1[3], c2[3];
    w_t a, e, f, c, b, den, tn, td, dd, thw;
    logic [30:0] s, t;
    bit g1, g2;
    near_t res;
    for (int i = 0; i < 3; i++) begin
      p1[i] = $signed(pt[i]);
      q1[i] = $signed(pt[3 + i]);
      p2[i] = $signed(pt[6 + i]);
      q2[i] = $signed(pt[9 + i]);
      d1[i] = q1[i] - p1[i];
      d2[i] = q2[i] - p2[i];
      r[i] = p1[i] - p2[i];
    end
    a = dot3(d1, d1);
    e = dot3(d2, d2);
    f = dot3(d2, r);
    thw = {136'b0, thr};
    g1 = a <= thw;
    g2 = e <= thw;
    s = '0;
    t = '0;
    if (g1 && !g2) begin
      t = frac_of(f, e);
    end else if (!g1) begin
      c = dot3(d1, r);
      if (g2) begin
        s = frac_of(-c, a);
      end else begin
        b = dot3(d1, d2);
        den = a * e - b * b;
        s = (den > 0) ? frac_of(b * f - c * e, den) : '0;
        tn = b * w_t'(s) + (f <<< T_FRAC);
        td = e <<< T_FRAC;
        if (tn < 0) begin
          s = frac_of(-c, a);
        end else if (tn > td) begin
          t = 31'(1) << T_FRAC;
          s = frac_of(b - c, a);
        end else begin
          t = frac_of(tn, td);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      c1[i] = along(p1[i], d1[i], s);
      c2[i] = along(p2[i], d2[i], t);
      x[i] = c1[i] - c2[i];
      res.n1[i] = c1[i][31:0];
      res.n2[i] = c2[i][31:0];
    end
    dd = dot3(x, x);
    res.dsq = (dd >= (w_t'(1) <<< 64)) ? 64'hFFFF_FFFF_FFFF_FFFF : dd[63:0];
    return res;
  endfunction

  // result side: stall bursts and long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_req <= hold_req - 1;
    end else if (stall_burst > 0) begin
      out_stall <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_burst <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(negedge clk) begin
    near_t want;
    logic [31:0] got1[3], got2[3];
    if (rst_n && out_valid && !out_stall) begin
      got1 = '{out_n1_x, out_n1_y, out_n1_z};
      got2 = '{out_n2_x, out_n2_y, out_n2_z};
      if (exp_near_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        want = exp_near_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got1[i] !== want.n1[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("near1[%0d]: expected %h got %h", i, want.n1[i], got1[i]);
          end
          if (got2[i] !== want.n2[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("near2[%0d]: expected %h got %h", i, want.n2[i], got2[i]);
          end
        end
        if (out_dsq !== want.dsq) begin
          mismatches++;
          if (mismatches <= 10) $display("dist_squared: expected %h got %h", want.dsq, out_dsq);
        end
      end
    end
  end

  task automatic send_pair(seg_pair_t pt);
    logic st;
    in_valid <= 1'b1;
    in_pt <= pt;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    exp_near_q.push_back(closest_points(pt, thr_model));
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (exp_near_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_threshold(logic [63:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    thr_model = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] near_to(logic [31:0] c, int span);
    return c + 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t pt;
    logic [31:0] ctr;
    int span, kind, k;
    kind = $urandom_range(0, 9);
    ctr = $urandom() >> $urandom_range(1, 31);
    if ($urandom_range(0, 1)) ctr = -ctr;
    span = 1 << $urandom_range(4, 22);
    for (int i = 0; i < 12; i++) pt[i] = near_to(ctr, span);
    case (kind)
      0: for (int i = 0; i < 12; i++) pt[i] = $urandom();
      1: for (int i = 0; i < 3; i++) pt[3 + i] = near_to(pt[i], 20000);
      2: for (int i = 0; i < 3; i++) pt[9 + i] = near_to(pt[6 + i], 20000);
      3: for (int i = 0; i < 3; i++) begin
        pt[3 + i] = near_to(pt[i], 20000);
        pt[9 + i] = near_to(pt[6 + i], 20000);
      end
      4: begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++) pt[9 + i] = pt[6 + i] + k * (pt[3 + i] - pt[i]);
      end
      5: for (int i = 0; i < 3; i++) pt[9 + i] = pt[6 + i] - (pt[3 + i] - pt[i]);
      default: ;
    endcase
    return pt;
  endfunction

  task automatic test_directed();
    seg_pair_t pt;
    pt = '0;
    send_pair(pt);
    pt = '{default: 32'h8000_0000};
    send_pair(pt);
    pt = '{default: 32'h7FFF_FFFF};
    send_pair(pt);
    for (int i = 0; i < 12; i++) pt[i] = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
    send_pair(pt);
    for (int i = 0; i < 12; i++) pt[i] = ((i / 3) % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_pair(pt);
    // crossing segments along x and y, offset in z
    pt = '{32'hFFFF_0000, 0, 0, 32'h0001_0000, 0, 0,
           0, 32'hFFFF_0000, 32'h0002_0000, 0, 32'h0001_0000, 32'h0002_0000};
    send_pair(pt);
    // first segment a point, second a point, both points
    pt = '{32'h0001_0000, 5, 7, 32'h0001_0000, 5, 7, 0, 0, 0, 32'h0004_0000, 0, 0};
    send_pair(pt);
    pt = '{0, 0, 0, 32'h0004_0000, 0, 0, 32'h0002_0000, 32'h0003_0000, 9, 32'h0002_0000,
           32'h0003_0000, 9};
    send_pair(pt);
    pt = '{1, 2, 3, 1, 2, 3, 32'hFFF0_0000, 4, 5, 32'hFFF0_0000, 4, 5};
    send_pair(pt);
    // parallel and antiparallel lines
    pt = '{0, 0, 0, 32'h0004_0000, 0, 0, 32'h0002_0000, 32'h0001_0000, 0,
           32'h0006_0000, 32'h0001_0000, 0};
    send_pair(pt);
    pt = '{0, 0, 0, 32'h0004_0000, 0, 0, 32'h0009_0000, 32'h0001_0000, 0,
           32'h0005_0000, 32'h0001_0000, 0};
    send_pair(pt);
    // t clamped below and above
    pt = '{0, 0, 0, 32'h0001_0000, 0, 0, 32'h0000_8000, 32'h0001_0000, 0,
           32'h0000_8000, 32'h0003_0000, 0};
    send_pair(pt);
    pt = '{0, 0, 0, 32'h0001_0000, 0, 0, 32'h0000_8000, 32'hFFFD_0000, 0,
           32'h0000_8000, 32'hFFFF_0000, 0};
    send_pair(pt);
    // far-apart points: distance saturates
    pt = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_pair(pt);
  endtask

  task automatic test_thresholds();
    logic [63:0] thr_set[4];
    thr_set = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1 << 40, {$urandom(), $urandom()}};
    foreach (thr_set[j]) begin
      write_threshold(thr_set[j]);
      test_directed();
      repeat (40) send_pair(rand_pair());
    end
    write_threshold(THR_RST);
  endtask

  task automatic test_random(int n);
    repeat (n) send_pair(rand_pair());
  endtask

  task automatic test_backpressure();
    hold_req <= 400;
    repeat (200) send_pair(rand_pair());
  endtask

  task automatic test_sender_pause();
    test_random(50);
    in_valid <= 1'b0;
    wait (exp_near_q.size() == 0);
    @(posedge clk);
    test_random(50);
  endtask

  initial begin
    thr_model = THR_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_random(400);
    test_backpressure();
    test_sender_pause();
    idle_on = 1'b0;
    test_random(150);
    in_valid <= 1'b0;
    wait (exp_near_q.size() == 0);
    repeat (120) @(posedge clk);
    if (mismatches == 0) begin
      $display("segment_segment_closest_points_unit verification clean");
    end else begin
      $display("segment_segment_closest_points_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ssc_pkg.sv
rtl/ssc_mul.sv
rtl/ssc_div.sv
rtl/ssc_front.sv
rtl/ssc_fifo.sv
rtl/ssc_back.sv
rtl/segment_segment_closest_points_unit.sv
bench/tb_segment_segment_closest_points_unit.sv
